@@ hdl/gtc_pkg.sv @@
// Package for the gyro tremor classifier: shared types and constants.
// No dependencies.
`timescale 1ns / 1ps
package gtc_pkg;
    localparam int AXES = 3;
    localparam logic [1:0] REG_DEV  = 2'd0;
    localparam logic [1:0] REG_MIN  = 2'd1;
    localparam logic [1:0] REG_AMP  = 2'd2;

    typedef struct packed {
        logic load;      // capture input, update window and sums
        logic num_start; // add new square, drop oldest sample from sums
        logic div_start; // form numerator and divisor, start divider
        logic finish;    // capture result
    } t_cmd;

    typedef struct packed {
        logic div_done;
    } t_status;
endpackage

@@ hdl/gtc_ctrl.sv @@
// Controller for the gyro tremor classifier.
// Depends on gtc_pkg.
`timescale 1ns / 1ps
module gtc_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    input  gtc_pkg::t_status   i_status,
    output gtc_pkg::t_cmd      o_cmd
);
    import gtc_pkg::*;
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_NUM  = 3'd1;
    localparam logic [2:0] S_DIVS = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;

    logic [2:0] r_state, n_state;
    logic       r_ovalid, n_ovalid;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_ovalid;

    always_comb begin
        n_state  = r_state;
        n_ovalid = r_ovalid;
        o_cmd    = '0;
        if (r_ovalid && i_out_ready) n_ovalid = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = S_NUM;
                end
            end
            S_NUM: begin
                o_cmd.num_start = 1'b1;
                n_state = S_DIVS;
            end
            S_DIVS: begin
                o_cmd.div_start = 1'b1;
                n_state = S_DIV;
            end
            S_DIV: begin
                if (i_status.div_done && (!r_ovalid || i_out_ready)) begin
                    o_cmd.finish = 1'b1;
                    n_ovalid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

    a_no_load_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |-> r_state == S_IDLE) else $error("load while busy");
    a_finish_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |-> i_status.div_done) else $error("finish before divide");
    a_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> o_cmd.num_start ##1 o_cmd.div_start)
        else $error("sequence broken");
endmodule

@@ hdl/gtc_datapath.sv @@
// Datapath for the gyro tremor classifier: window store, running sums,
// three bit-serial dividers, one shared divisor. Depends on gtc_pkg.
`timescale 1ns / 1ps
module gtc_datapath #(
    parameter int WINDOW_LEN = 15
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  gtc_pkg::t_cmd         i_cmd,
    output gtc_pkg::t_status      o_status,
    input  logic [47:0]           i_sample,
    input  logic                  i_cfg_we,
    input  logic [1:0]            i_cfg_idx,
    input  logic [15:0]           i_cfg_data,
    output logic [95:0]           o_var,
    output logic [2:0]            o_tremor
);
    import gtc_pkg::*;
    localparam int IW = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
    localparam int CW = $clog2(WINDOW_LEN + 1);
    localparam int SW = 16 + CW + 1;
    localparam int QW = 32 + CW + 1;
    localparam int NW = QW + CW;
    localparam int DW = 2 * CW;
    localparam int QCW = $clog2(NW + 1);

    logic [15:0] r_dev, r_minm, r_amp;
    logic [47:0] r_win [WINDOW_LEN];
    logic [47:0] r_old;
    logic        r_full;
    logic [CW-1:0] r_fill;
    logic [IW-1:0] r_slot;
    logic signed [SW-1:0] r_sum [AXES];
    logic [QW-1:0] r_sq [AXES];
    logic [15:0] r_mag [AXES];
    logic [NW-1:0] r_num [AXES];
    logic [NW-1:0] r_rem [AXES];
    logic [NW-1:0] r_quo [AXES];
    logic [DW-1:0] r_div;
    logic [QCW-1:0] r_cnt;
    logic        r_busy;
    logic [95:0] r_var;
    logic [2:0]  r_trem;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev <= 16'd4912;
            r_minm <= 16'd164;
            r_amp <= 16'd16373;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_DEV: r_dev <= i_cfg_data;
                REG_MIN: r_minm <= i_cfg_data;
                REG_AMP: r_amp <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // window entry read before load; data from a fresh slot is unused
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_win[r_slot] <= i_sample;
        end
        r_old <= r_win[r_slot];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_slot <= '0;
            r_full <= 1'b0;
            r_busy <= 1'b0;
            r_cnt <= '0;
            for (int a = 0; a < AXES; a++) begin
                r_sum[a] <= '0;
                r_sq[a] <= '0;
            end
        end else begin
            if (i_cmd.load) begin
                r_full <= (r_fill == CW'(WINDOW_LEN));
                if (r_fill != CW'(WINDOW_LEN)) r_fill <= r_fill + 1'b1;
                r_slot <= (r_slot == IW'(WINDOW_LEN - 1)) ? '0 : r_slot + 1'b1;
                for (int a = 0; a < AXES; a++) begin
                    r_mag[a] <= i_sample[16*a+15] ? 16'(-i_sample[16*a +: 16])
                                                  : i_sample[16*a +: 16];
                    r_sum[a] <= r_sum[a] + SW'($signed(i_sample[16*a +: 16]));
                end
            end
            if (i_cmd.num_start) begin
                for (int a = 0; a < AXES; a++) begin
                    logic signed [SW-1:0] s;
                    logic [15:0] om;
                    logic [QW-1:0] q;
                    om = r_old[16*a+15] ? 16'(-r_old[16*a +: 16]) : r_old[16*a +: 16];
                    s = r_sum[a] - (r_full ? SW'($signed(r_old[16*a +: 16])) : SW'(0));
                    q = r_sq[a] + QW'(r_mag[a]) * QW'(r_mag[a])
                        - (r_full ? QW'(om) * QW'(om) : QW'(0));
                    r_sum[a] <= s;
                    r_sq[a] <= q;
                end
            end
            if (i_cmd.div_start) begin
                r_busy <= 1'b1;
                r_cnt <= QCW'(NW);
            end else if (r_busy && r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
            end
            if (i_cmd.finish) r_busy <= 1'b0;
        end
    end

    // numerator: n*sumsq - sum^2, built in the cycle after sums settle
    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_div <= DW'(r_fill) * DW'(r_fill);
            for (int a = 0; a < AXES; a++) begin
                logic [SW-1:0] sa;
                sa = r_sum[a][SW-1] ? SW'(-r_sum[a]) : SW'(r_sum[a]);
                r_num[a] <= NW'(r_fill) * NW'(r_sq[a]) - NW'(sa) * NW'(sa);
                r_rem[a] <= '0;
                r_quo[a] <= '0;
            end
        end else if (r_busy && r_cnt != '0) begin
            for (int a = 0; a < AXES; a++) begin
                logic [NW:0] t;
                t = {r_rem[a], r_num[a][NW-1]};
                if (t >= (NW+1)'(r_div)) begin
                    r_rem[a] <= NW'(t - (NW+1)'(r_div));
                    r_quo[a] <= {r_quo[a][NW-2:0], 1'b1};
                end else begin
                    r_rem[a] <= NW'(t);
                    r_quo[a] <= {r_quo[a][NW-2:0], 1'b0};
                end
                r_num[a] <= {r_num[a][NW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            for (int a = 0; a < AXES; a++) begin
                logic [16:0] m;
                logic [31:0] lim;
                m = (r_mag[a] == 16'h8000) ? 17'h08000 : {1'b0, r_mag[a]};
                lim = 32'(r_dev) * 32'(r_dev);
                r_var[32*a +: 32] <= {1'b0, r_quo[a][30:0]};
                r_trem[a] <= (r_quo[a] < NW'(lim)) && (m >= 17'(r_minm))
                             && (m < 17'(r_amp));
            end
        end
    end

    assign o_status.div_done = r_busy && (r_cnt == '0);
    assign o_var = r_var;
    assign o_tremor = r_trem;
endmodule

@@ hdl/gyro_tremor_classifier_unit.sv @@
// Gyro tremor classifier: per-axis sliding-window variance and tremor flags.
// One input transaction is taken at a time and yields one output transaction.
// No new input is taken until the result of the last one is captured. The
// quotient has NW bits (NW = numerator width, 41 at WINDOW_LEN 15), formed by
// three one-bit-per-cycle restoring dividers that share one divisor and step
// count; a stalled result holds off the capture of the next one.
// Depends on gtc_pkg, gtc_ctrl, gtc_datapath.
`timescale 1ns / 1ps
module gyro_tremor_classifier_unit #(
    parameter int WINDOW_LEN = 15
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // gx_raw, gy_raw, gz_raw
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [95:0] m_axis_tdata,   // var_x, var_y, var_z
    output logic [7:0]  m_axis_tuser,   // tremor_x, tremor_y, tremor_z, zero
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data
);
    import gtc_pkg::*;
    t_cmd    w_cmd;
    t_status w_status;
    logic [95:0] w_var;
    logic [2:0]  w_trem;

    gtc_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(s_axis_tvalid), .o_in_ready(s_axis_tready),
        .o_out_valid(m_axis_tvalid), .i_out_ready(m_axis_tready),
        .i_status(w_status), .o_cmd(w_cmd)
    );

    gtc_datapath #(.WINDOW_LEN(WINDOW_LEN)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_cmd), .o_status(w_status),
        .i_sample(s_axis_tdata), .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data), .o_var(w_var), .o_tremor(w_trem)
    );

    assign m_axis_tdata = {1'b0, w_var[94:64], w_var[62:32], w_var[30:0], 2'b00} >> 2;
    assign m_axis_tuser = {5'b0, w_trem};
endmodule
